/* sv/utf8_stream_confidence_core_assert.svh */
// assertion helpers for the utf8 confidence core
`ifndef UTF8_STREAM_CONFIDENCE_CORE_ASSERT_SVH
`define UTF8_STREAM_CONFIDENCE_CORE_ASSERT_SVH

// same-cycle implication, disabled while reset is asserted
`define UTF8SC_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is asserted
`define UTF8SC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* sv/utf8sc_pkg.sv */
package utf8sc_pkg;

    localparam int unsigned MAX_BYTES = 1048576;
    localparam int unsigned CNT_W     = 21;
    localparam int unsigned CNT_MAX   = (1 << CNT_W) - 1;

    typedef logic [CNT_W-1:0] t_cnt;
    typedef logic [2:0]       t_score;

    localparam t_cnt CNT_LIMIT =
        t_cnt'((MAX_BYTES < CNT_MAX) ? MAX_BYTES : CNT_MAX);

    // a bad lead that lifts the invalid count beyond this stops the heuristic scan
    localparam t_cnt STOP_LIMIT = t_cnt'(5);
    // more valid sequences than this, with no invalid one, give full confidence without a bom
    localparam t_cnt GRADE_MIN_VALID = t_cnt'(3);

    localparam t_score SCORE_NONE = 3'd0;
    localparam t_score SCORE_LOW  = 3'd1;
    localparam t_score SCORE_HALF = 3'd2;
    localparam t_score SCORE_HIGH = 3'd3;
    localparam t_score SCORE_FULL = 3'd4;

    localparam int unsigned IN_TDATA_W  = 8;
    localparam int unsigned OUT_TDATA_W = 48;

    // continuation byte range for the next trail byte
    typedef enum logic [1:0] {
        RANGE_NORMAL     = 2'd0,
        RANGE_RAISED_LO  = 2'd1,
        RANGE_LOWERED_HI = 2'd2
    } t_range;

    localparam logic [7:0] BOM_B0 = 8'hEF;
    localparam logic [7:0] BOM_B1 = 8'hBB;
    localparam logic [7:0] BOM_B2 = 8'hBF;

    // end-of-text summary handed from the scanner to the grader
    typedef struct packed {
        logic check_mode;
        logic exact_fail;
        logic bom;
        t_cnt valid_cnt;
        t_cnt invalid_cnt;
    } t_summary;

    // result word, lowest bits last in the list
    typedef struct packed {
        logic [1:0] pad;
        logic       bom_present;
        t_cnt       invalid_sequences;
        t_cnt       valid_sequences;
        t_score     score_quarters;
    } t_result;

    function automatic logic [7:0] bom_byte(input logic [1:0] pos);
        logic [7:0] b;
        unique case (pos)
            2'd0:    b = BOM_B0;
            2'd1:    b = BOM_B1;
            default: b = BOM_B2;
        endcase
        return b;
    endfunction

    function automatic t_cnt sat_inc(input t_cnt v);
        return (v < CNT_LIMIT) ? v + t_cnt'(1) : v;
    endfunction

endpackage

/* sv/utf8_stream_confidence_core.sv */
// utf8 stream confidence core: takes a text one byte per transaction on the
// s_axis side (tlast on the final byte) and returns one result transaction on
// the m_axis side per text. check_mode = 1 gives a heuristic grade in quarters
// with counts of valid and invalid multibyte sequences and a bom flag;
// check_mode = 0 gives 4 when the text is well-formed utf-8 with no zero byte,
// else 0, with the other fields zero. check_mode is taken at the final byte and
// should only be written between texts. One byte is accepted every cycle while
// the output side keeps up; after the final byte of a text is accepted it passes
// through the input register, the summary register takes the end-of-text state
// and the result register holds the grade, which raises m_axis_tvalid.
// A final byte waits in the input register, holding s_axis_tready low, while
// the summary and result registers are both full and the result is not taken.
// Sequence counters saturate at 1048576.
module utf8_stream_confidence_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration: check_mode
    input  logic        i_cfg_we,
    input  logic        i_cfg_wdata,
    // byte stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  logic        s_axis_tlast,   // last_byte
    // results
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata    // [2:0] score_quarters, [23:3] valid_sequences,
                                        // [44:24] invalid_sequences, [45] bom_present,
                                        // [47:46] zero
);

    logic                          r_check_mode;

    // stage a: input register
    logic                          r_a_valid;
    logic [utf8sc_pkg::IN_TDATA_W-1:0] r_a_byte;
    logic                          r_a_last;

    // stage b: end-of-text summary
    logic                          r_b_valid;
    utf8sc_pkg::t_summary          r_b_sum;

    // stage c: output register
    logic                          r_c_valid;
    utf8sc_pkg::t_result           r_c_data;

    logic                          c_free;
    logic                          b_free;
    logic                          a_adv;
    logic                          a_done;
    utf8sc_pkg::t_summary          scan_sum;
    logic                          scan_idle;
    utf8sc_pkg::t_result           grade_result;

    // flow control: a stage moves on when the one after it is empty or moving
    assign c_free = !r_c_valid || m_axis_tready;
    assign b_free = !r_b_valid || c_free;
    // a plain byte only touches scan state; a final byte also needs stage b
    assign a_adv  = r_a_valid && (!r_a_last || b_free);
    assign a_done = a_adv && r_a_last;

    assign s_axis_tready = !r_a_valid || a_adv;
    assign m_axis_tvalid = r_c_valid;
    assign m_axis_tdata  = r_c_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_check_mode <= 1'b1;
        end else if (i_cfg_we) begin
            r_check_mode <= i_cfg_wdata;
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_a_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_a_byte <= s_axis_tdata;
            r_a_last <= s_axis_tlast;
        end
    end

    // byte scanner: bom, sequence decode, counters, exact check
    utf8sc_scan u_scan (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_en         (a_adv),
        .i_byte       (r_a_byte),
        .i_last       (r_a_last),
        .i_check_mode (r_check_mode),
        .o_sum        (scan_sum),
        .o_idle       (scan_idle)
    );

    // summary register, loaded on the final byte of a text
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else if (b_free) begin
            r_b_valid <= a_done;
        end
    end

    always_ff @(posedge i_clk) begin
        if (a_done) begin
            r_b_sum <= scan_sum;
        end
    end

    // grading and mode selection
    utf8sc_grade u_grade (
        .i_sum    (r_b_sum),
        .o_result (grade_result)
    );

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_valid <= 1'b0;
        end else if (c_free) begin
            r_c_valid <= r_b_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (c_free && r_b_valid) begin
            r_c_data <= grade_result;
        end
    end

`include "utf8_stream_confidence_core_assert.svh"

    // a score never exceeds four quarters
    `UTF8SC_ASSERT_NOW(a_score_range, i_clk, i_rst_n, r_c_valid,
        r_c_data.score_quarters <= utf8sc_pkg::SCORE_FULL, "score out of range")
    // full confidence implies no invalid sequence was seen
    `UTF8SC_ASSERT_NOW(a_full_clean, i_clk, i_rst_n,
        r_c_valid && (r_c_data.score_quarters == utf8sc_pkg::SCORE_FULL),
        r_c_data.invalid_sequences == '0, "full score with invalid sequences")
    // a final byte blocked by a full summary stage holds the input
    `UTF8SC_ASSERT_NOW(a_last_blocks, i_clk, i_rst_n,
        r_a_valid && r_a_last && r_b_valid && !c_free,
        !s_axis_tready, "input accepted past a blocked final byte")
    // scan state is back at its reset values after each text
    `UTF8SC_ASSERT_NEXT(a_scan_cleared, i_clk, i_rst_n, a_done,
        scan_idle, "scan state not cleared after final byte")

endmodule

/* sv/utf8sc_scan.sv */
module utf8sc_scan (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  logic [7:0]           i_byte,
    input  logic                 i_last,
    input  logic                 i_check_mode,
    output utf8sc_pkg::t_summary o_sum,
    output logic                 o_idle
);

    logic [1:0]        r_pos,     n_pos;
    logic              r_bom,     n_bom;
    logic [1:0]        r_trail,   n_trail;
    utf8sc_pkg::t_range r_kind,   n_kind;
    logic              r_stopped, n_stopped;
    logic              r_fail,    n_fail;
    utf8sc_pkg::t_cnt  r_valid,   n_valid;
    utf8sc_pkg::t_cnt  r_invalid, n_invalid;
    logic [7:0]        lo, hi;

    always_comb begin
        n_pos     = r_pos;
        n_bom     = r_bom;
        n_trail   = r_trail;
        n_kind    = r_kind;
        n_stopped = r_stopped;
        n_fail    = r_fail;
        n_valid   = r_valid;
        n_invalid = r_invalid;
        lo        = 8'h80;
        hi        = 8'hBF;

        // bom tracking over the first three bytes
        if (r_pos != 2'd3) begin
            if (i_byte != utf8sc_pkg::bom_byte(r_pos)) begin
                n_bom = 1'b0;
            end
            n_pos = r_pos + 2'd1;
        end
        if (i_byte == 8'h00) begin
            n_fail = 1'b1;
        end

        if (!r_stopped) begin
            if (r_trail != 2'd0) begin
                // inside a sequence
                if (i_byte[7:6] != 2'b10) begin
                    n_fail    = 1'b1;
                    n_invalid = utf8sc_pkg::sat_inc(r_invalid);
                    n_trail   = 2'd0;
                    n_kind    = utf8sc_pkg::RANGE_NORMAL;
                end else begin
                    unique case (r_kind)
                        utf8sc_pkg::RANGE_RAISED_LO:
                            lo = (r_trail == 2'd3) ? 8'h90 : 8'hA0;
                        utf8sc_pkg::RANGE_LOWERED_HI:
                            hi = (r_trail == 2'd3) ? 8'h8F : 8'h9F;
                        default: ;
                    endcase
                    if (i_byte < lo || i_byte > hi) begin
                        n_fail = 1'b1;
                    end
                    n_kind  = utf8sc_pkg::RANGE_NORMAL;
                    n_trail = r_trail - 2'd1;
                    if (r_trail == 2'd1) begin
                        n_valid = utf8sc_pkg::sat_inc(r_valid);
                    end
                end
            end else if (i_byte[7]) begin
                // lead byte
                priority if (i_byte[7:5] == 3'b110) begin
                    n_trail = 2'd1;
                end else if (i_byte[7:4] == 4'b1110) begin
                    n_trail = 2'd2;
                end else if (i_byte[7:3] == 5'b11110) begin
                    n_trail = 2'd3;
                end else begin
                    n_trail = 2'd0;
                end
                if (n_trail == 2'd0) begin
                    n_fail    = 1'b1;
                    n_invalid = utf8sc_pkg::sat_inc(r_invalid);
                    if (n_invalid > utf8sc_pkg::STOP_LIMIT) begin
                        n_stopped = 1'b1;
                    end
                end else begin
                    n_kind = utf8sc_pkg::RANGE_NORMAL;
                    priority if (i_byte < 8'hC2 || i_byte > 8'hF4) begin
                        n_fail = 1'b1;
                    end else if (i_byte == 8'hE0 || i_byte == 8'hF0) begin
                        n_kind = utf8sc_pkg::RANGE_RAISED_LO;
                    end else if (i_byte == 8'hED || i_byte == 8'hF4) begin
                        n_kind = utf8sc_pkg::RANGE_LOWERED_HI;
                    end else begin
                        n_kind = utf8sc_pkg::RANGE_NORMAL;
                    end
                end
            end
        end
    end

    // summary of the text as it stands after this byte
    always_comb begin
        o_sum.check_mode  = i_check_mode;
        o_sum.exact_fail  = n_fail | (n_trail != 2'd0);
        o_sum.bom         = n_bom & (n_pos == 2'd3);
        o_sum.valid_cnt   = n_valid;
        o_sum.invalid_cnt = n_invalid;
    end

    assign o_idle = (r_pos == 2'd0) && r_bom && (r_trail == 2'd0)
                 && (r_kind == utf8sc_pkg::RANGE_NORMAL) && !r_stopped && !r_fail
                 && (r_valid == '0) && (r_invalid == '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_en && i_last)) begin
            r_pos     <= 2'd0;
            r_bom     <= 1'b1;
            r_trail   <= 2'd0;
            r_kind    <= utf8sc_pkg::RANGE_NORMAL;
            r_stopped <= 1'b0;
            r_fail    <= 1'b0;
            r_valid   <= '0;
            r_invalid <= '0;
        end else if (i_en) begin
            r_pos     <= n_pos;
            r_bom     <= n_bom;
            r_trail   <= n_trail;
            r_kind    <= n_kind;
            r_stopped <= n_stopped;
            r_fail    <= n_fail;
            r_valid   <= n_valid;
            r_invalid <= n_invalid;
        end
    end

endmodule

/* sv/utf8sc_grade.sv */
module utf8sc_grade (
    input  utf8sc_pkg::t_summary i_sum,
    output utf8sc_pkg::t_result  o_result
);

    logic [utf8sc_pkg::CNT_W+3:0] inv_x10;
    logic                         valid_dominates;
    logic                         no_invalid;
    utf8sc_pkg::t_score           heur_score;

    // invalid * 10 as two shifted adds
    assign inv_x10 = (utf8sc_pkg::CNT_W+4)'({i_sum.invalid_cnt, 3'b000})
                   + (utf8sc_pkg::CNT_W+4)'({i_sum.invalid_cnt, 1'b0});
    assign valid_dominates = (utf8sc_pkg::CNT_W+4)'(i_sum.valid_cnt) > inv_x10;
    assign no_invalid      = (i_sum.invalid_cnt == '0);

    always_comb begin
        priority if (i_sum.bom && no_invalid) begin
            heur_score = utf8sc_pkg::SCORE_FULL;
        end else if (i_sum.bom && valid_dominates) begin
            heur_score = utf8sc_pkg::SCORE_HIGH;
        end else if (i_sum.valid_cnt > utf8sc_pkg::GRADE_MIN_VALID && no_invalid) begin
            heur_score = utf8sc_pkg::SCORE_FULL;
        end else if (no_invalid) begin
            heur_score = utf8sc_pkg::SCORE_HALF;
        end else if (valid_dominates) begin
            heur_score = utf8sc_pkg::SCORE_LOW;
        end else begin
            heur_score = utf8sc_pkg::SCORE_NONE;
        end
    end

    always_comb begin
        o_result.pad = 2'b00;
        if (i_sum.check_mode) begin
            o_result.score_quarters    = heur_score;
            o_result.valid_sequences   = i_sum.valid_cnt;
            o_result.invalid_sequences = i_sum.invalid_cnt;
            o_result.bom_present       = i_sum.bom;
        end else begin
            o_result.score_quarters    = i_sum.exact_fail ? utf8sc_pkg::SCORE_NONE
                                                          : utf8sc_pkg::SCORE_FULL;
            o_result.valid_sequences   = '0;
            o_result.invalid_sequences = '0;
            o_result.bom_present       = 1'b0;
        end
    end

endmodule

/* verif/utf8_stream_confidence_core_tb.sv */
`timescale 1ns / 1ps

module utf8_stream_confidence_core_tb;

    // generous bound, a slow correct run needs far fewer cycles
    localparam int CYCLE_LIMIT = 400000;
    // pause after the last result so a stray result would still show up
    localparam int SETTLE_CYCLES = 8;
    // receiver hold-off used to back the core up
    localparam int HOLD_CYCLES = 300;

    // one byte of text plus its end-of-text marker
    typedef struct {
        logic [7:0] data;
        logic       last;
    } t_text_byte;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic        i_cfg_wdata = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = 8'h00;    // [7:0] data_byte
    logic        s_axis_tlast = 1'b0;     // last_byte
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [47:0] m_axis_tdata;            // [2:0] score_quarters, [23:3] valid_sequences,
                                          // [44:24] invalid_sequences, [45] bom_present

    // bytes waiting to be offered, and results the core still owes us
    t_text_byte           byte_queue[$];
    utf8sc_pkg::t_result  expected_results[$];

    int          bytes_queued = 0;
    int          mismatch_count = 0;
    int          results_seen = 0;
    int          cycle_count = 0;
    int          send_idle_pct = 0;
    int          recv_idle_pct = 0;
    int          hold_requests = 0;
    int          hold_served = 0;
    int          hold_left = 0;

    t_text_byte           next_byte;
    utf8sc_pkg::t_result  seen_result;
    utf8sc_pkg::t_result  want_result;

    // our own copy of the scanner state and of check_mode
    logic                 mode_sel = 1'b1;
    logic [1:0]           scan_pos;
    logic                 bom_ok;
    logic [1:0]           trails_due;
    utf8sc_pkg::t_range   range_kind;
    logic                 scan_halted;
    logic                 exact_bad;
    utf8sc_pkg::t_cnt     valid_cnt;
    utf8sc_pkg::t_cnt     invalid_cnt;

    utf8_stream_confidence_core DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #5 i_clk = ~i_clk;

    // start of every text: scanner back to its idle state
    task automatic clear_scan();
        scan_pos    = 2'd0;
        bom_ok      = 1'b1;
        trails_due  = 2'd0;
        range_kind  = utf8sc_pkg::RANGE_NORMAL;
        scan_halted = 1'b0;
        exact_bad   = 1'b0;
        valid_cnt   = '0;
        invalid_cnt = '0;
    endtask

    initial clear_scan();

    task automatic report_mismatch(input string what, input longint got, input longint want);
        mismatch_count++;
        $display("mismatch at result %0d: %s got %0d expected %0d",
                 results_seen, what, got, want);
    endtask

    // advance the scanner by one accepted byte, queue the result on the last one
    task automatic scan_byte(input logic [7:0] b, input logic last);
        logic [7:0]          bom_want;
        logic [7:0]          lo;
        logic [7:0]          hi;
        logic [1:0]          n_trail;
        logic                bom;
        longint              v;
        longint              n;
        utf8sc_pkg::t_result r;

        // byte order mark only counts in the first three bytes
        if (scan_pos != 2'd3) begin
            case (scan_pos)
                2'd0:    bom_want = utf8sc_pkg::BOM_B0;
                2'd1:    bom_want = utf8sc_pkg::BOM_B1;
                default: bom_want = utf8sc_pkg::BOM_B2;
            endcase
            if (b != bom_want) bom_ok = 1'b0;
            scan_pos = scan_pos + 2'd1;
        end
        if (b == 8'h00) exact_bad = 1'b1;

        if (!scan_halted) begin
            if (trails_due != 2'd0) begin
                if (b[7:6] != 2'b10) begin
                    // broken sequence, the byte is swallowed
                    exact_bad = 1'b1;
                    if (invalid_cnt != utf8sc_pkg::CNT_LIMIT)
                        invalid_cnt = invalid_cnt + utf8sc_pkg::t_cnt'(1);
                    trails_due = 2'd0;
                    range_kind = utf8sc_pkg::RANGE_NORMAL;
                end else begin
                    lo = 8'h80;
                    hi = 8'hBF;
                    if (range_kind == utf8sc_pkg::RANGE_RAISED_LO) begin
                        lo = (trails_due == 2'd3) ? 8'h90 : 8'hA0;
                    end else if (range_kind == utf8sc_pkg::RANGE_LOWERED_HI) begin
                        hi = (trails_due == 2'd3) ? 8'h8F : 8'h9F;
                    end
                    if (b < lo || b > hi) exact_bad = 1'b1;
                    range_kind = utf8sc_pkg::RANGE_NORMAL;
                    trails_due = trails_due - 2'd1;
                    if (trails_due == 2'd0 && valid_cnt != utf8sc_pkg::CNT_LIMIT)
                        valid_cnt = valid_cnt + utf8sc_pkg::t_cnt'(1);
                end
            end else if (b[7]) begin
                if (b[7:5] == 3'b110)        n_trail = 2'd1;
                else if (b[7:4] == 4'b1110)  n_trail = 2'd2;
                else if (b[7:3] == 5'b11110) n_trail = 2'd3;
                else                         n_trail = 2'd0;
                if (n_trail == 2'd0) begin
                    // bad lead, one that lifts the invalid count too high stops the heuristic
                    exact_bad = 1'b1;
                    if (invalid_cnt != utf8sc_pkg::CNT_LIMIT)
                        invalid_cnt = invalid_cnt + utf8sc_pkg::t_cnt'(1);
                    if (invalid_cnt > utf8sc_pkg::STOP_LIMIT) scan_halted = 1'b1;
                end else begin
                    trails_due = n_trail;
                    range_kind = utf8sc_pkg::RANGE_NORMAL;
                    if (b < 8'hC2 || b > 8'hF4) begin
                        exact_bad = 1'b1;
                    end else if (b == 8'hE0 || b == 8'hF0) begin
                        range_kind = utf8sc_pkg::RANGE_RAISED_LO;
                    end else if (b == 8'hED || b == 8'hF4) begin
                        range_kind = utf8sc_pkg::RANGE_LOWERED_HI;
                    end
                end
            end
        end

        if (last) begin
            // a sequence cut off by the end only fails the exact check
            if (trails_due != 2'd0) exact_bad = 1'b1;
            r = '0;
            if (mode_sel) begin
                bom = bom_ok && (scan_pos == 2'd3);
                v = longint'(valid_cnt);
                n = longint'(invalid_cnt);
                if (bom && n == 0)
                    r.score_quarters = utf8sc_pkg::SCORE_FULL;
                else if (bom && v > n * 10)
                    r.score_quarters = utf8sc_pkg::SCORE_HIGH;
                else if (v > longint'(utf8sc_pkg::GRADE_MIN_VALID) && n == 0)
                    r.score_quarters = utf8sc_pkg::SCORE_FULL;
                else if (n == 0)
                    r.score_quarters = utf8sc_pkg::SCORE_HALF;
                else if (v > n * 10)
                    r.score_quarters = utf8sc_pkg::SCORE_LOW;
                else
                    r.score_quarters = utf8sc_pkg::SCORE_NONE;
                r.valid_sequences   = valid_cnt;
                r.invalid_sequences = invalid_cnt;
                r.bom_present       = bom;
            end else begin
                r.score_quarters = exact_bad ? utf8sc_pkg::SCORE_NONE
                                             : utf8sc_pkg::SCORE_FULL;
            end
            expected_results = {expected_results, r};
            clear_scan();
        end
    endtask

    // hand one text to the driver, tlast on its final byte
    task automatic queue_bytes(input logic [7:0] txt[$]);
        t_text_byte tb;
        foreach (txt[i]) begin
            tb.data = txt[i];
            tb.last = (i == txt.size() - 1);
            byte_queue = {byte_queue, tb};
        end
        bytes_queued += txt.size();
    endtask

    // random text: mostly well-formed sequences, noise_pct of the units broken or junk
    task automatic queue_text(input int units, input int noise_pct);
        logic [7:0] txt[$];
        logic [7:0] lead;
        int         kind;

        if ($urandom_range(4) == 0)
            txt = {utf8sc_pkg::BOM_B0, utf8sc_pkg::BOM_B1, utf8sc_pkg::BOM_B2};
        repeat (units) begin
            kind = $urandom_range(3);
            if ($urandom_range(99) < noise_pct) begin
                case (kind)
                    0: txt = {txt, 8'($urandom_range(255))};
                    1: begin
                        // any lead, including overlong and out-of-range ones, then anything
                        txt = {txt, 8'hC0 + 8'($urandom_range(55))};
                        txt = {txt, 8'($urandom_range(255))};
                    end
                    2: txt = {txt, 8'h00};
                    default: txt = {txt, 8'h80 + 8'($urandom_range(127))};
                endcase
            end else begin
                case (kind)
                    0: txt = {txt, 8'($urandom_range(127, 1))};
                    1: begin
                        txt = {txt, 8'hC2 + 8'($urandom_range(29))};
                        txt = {txt, 8'h80 + 8'($urandom_range(63))};
                    end
                    2: begin
                        // favor the leads with a narrowed second byte
                        case ($urandom_range(3))
                            0:       lead = 8'hE0;
                            1:       lead = 8'hED;
                            default: lead = 8'hE0 + 8'($urandom_range(15));
                        endcase
                        txt = {txt, lead};
                        if (lead == 8'hE0)
                            txt = {txt, 8'hA0 + 8'($urandom_range(31))};
                        else if (lead == 8'hED)
                            txt = {txt, 8'h80 + 8'($urandom_range(31))};
                        else
                            txt = {txt, 8'h80 + 8'($urandom_range(63))};
                        txt = {txt, 8'h80 + 8'($urandom_range(63))};
                    end
                    default: begin
                        lead = 8'hF0 + 8'($urandom_range(4));
                        txt = {txt, lead};
                        if (lead == 8'hF0)
                            txt = {txt, 8'h90 + 8'($urandom_range(47))};
                        else if (lead == 8'hF4)
                            txt = {txt, 8'h80 + 8'($urandom_range(15))};
                        else
                            txt = {txt, 8'h80 + 8'($urandom_range(63))};
                        txt = {txt, 8'h80 + 8'($urandom_range(63))};
                        txt = {txt, 8'h80 + 8'($urandom_range(63))};
                    end
                endcase
            end
        end
        // now and then chop the tail to leave a sequence unfinished
        if (txt.size() > 1 && $urandom_range(99) < noise_pct / 2 + 3) void'(txt.pop_back());
        queue_bytes(txt);
    endtask

    // short texts mostly, a few long ones to reach the graded-by-ratio cases
    task automatic queue_random(input int n_bytes, input int noise_pct);
        int goal;
        goal = bytes_queued + n_bytes;
        while (bytes_queued < goal) begin
            if ($urandom_range(19) == 0) queue_text($urandom_range(60, 30), noise_pct);
            else                         queue_text($urandom_range(12, 1), noise_pct);
        end
    endtask

    // everything sent, every result back, then let the pipeline settle
    task automatic drain_results();
        while (byte_queue.size() != 0 || s_axis_tvalid || expected_results.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // only called with the core idle
    task automatic write_mode(input logic m);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= m;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        mode_sel = m;
    endtask

    // byte driver: pops the next byte whenever the slot is free
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            // transaction completes on this edge
            if (s_axis_tvalid && s_axis_tready) begin
                scan_byte(s_axis_tdata, s_axis_tlast);
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (byte_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    next_byte = byte_queue.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= next_byte.data;
                    s_axis_tlast  <= next_byte.last;
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // result side ready, with random stalls and the occasional long hold-off
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left     <= hold_left - 1;
            m_axis_tready <= 1'b0;
        end else if (hold_served != hold_requests) begin
            hold_served   <= hold_served + 1;
            hold_left     <= HOLD_CYCLES;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // result monitor: compare each result transaction with the oldest expectation
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            seen_result = utf8sc_pkg::t_result'(m_axis_tdata);
            if (expected_results.size() == 0) begin
                report_mismatch("result with nothing pending, word",
                                longint'(m_axis_tdata), longint'(0));
            end else begin
                want_result = expected_results.pop_front();
                if (seen_result.score_quarters != want_result.score_quarters)
                    report_mismatch("score_quarters",
                                    longint'(seen_result.score_quarters),
                                    longint'(want_result.score_quarters));
                if (seen_result.valid_sequences != want_result.valid_sequences)
                    report_mismatch("valid_sequences",
                                    longint'(seen_result.valid_sequences),
                                    longint'(want_result.valid_sequences));
                if (seen_result.invalid_sequences != want_result.invalid_sequences)
                    report_mismatch("invalid_sequences",
                                    longint'(seen_result.invalid_sequences),
                                    longint'(want_result.invalid_sequences));
                if (seen_result.bom_present != want_result.bom_present)
                    report_mismatch("bom_present",
                                    longint'(seen_result.bom_present),
                                    longint'(want_result.bom_present));
            end
            results_seen++;
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    initial begin
        logic [7:0] txt[$];

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // phase 1: heuristic mode from reset, sender idles a little, receiver a lot
        send_idle_pct = 22;
        recv_idle_pct = 55;
        // bom followed by a two-byte sequence
        txt = {8'hEF, 8'hBB, 8'hBF, 8'hC3, 8'hA9};
        queue_bytes(txt);
        // single zero byte text
        txt = {8'h00};
        queue_bytes(txt);
        // six bad leads stop the scan, the valid pair after them is ignored
        txt = {8'hFF, 8'hFE, 8'h80, 8'hBF, 8'hF8, 8'hFC, 8'hC3, 8'hA9};
        queue_bytes(txt);
        // raised lower bound, broken sequence, unfinished tail
        txt = {8'hE0, 8'hA0, 8'h80, 8'hC3, 8'h41, 8'hF4};
        queue_bytes(txt);
        // four-byte sequence on the raised bound
        txt = {8'hF0, 8'h90, 8'h80, 8'h80};
        queue_bytes(txt);
        queue_random(300, 30);
        drain_results();

        // phase 2: exact check, mostly clean texts, idling swapped
        write_mode(1'b0);
        send_idle_pct = 55;
        recv_idle_pct = 22;
        queue_random(300, 8);
        drain_results();

        // phase 3: heuristic again, no idling, receiver held off so the core backs up
        write_mode(1'b1);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_requests++;
        repeat (150) begin
            txt = {8'($urandom_range(255))};
            queue_bytes(txt);
        end
        queue_random(120, 20);
        drain_results();

        // phase 4: exact check at full rate
        write_mode(1'b0);
        queue_random(180, 12);
        drain_results();

        if (mismatch_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

/* sim.f */
+incdir+sv
sv/utf8sc_pkg.sv
sv/utf8sc_scan.sv
sv/utf8sc_grade.sv
sv/utf8_stream_confidence_core.sv
verif/utf8_stream_confidence_core_tb.sv
